@@ rtl/bba_pkg.sv @@
// ----------------------------------------------------------------------------
// bba_pkg
// Shared widths, register indexes, microcode codes and the control program
// of the bitmap block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

   localparam int IDX_W    = 13;
   localparam int REG_W    = 14;
   localparam int LIM_W    = 15;
   localparam int CSR_IDX_W = 1;
   localparam int STEP_W   = 4;
   localparam int ACT_W    = 4;
   localparam int CND_W    = 4;

   // reciprocal shift for the divide-by-word-size unit
   localparam int DIV_SHIFT = 21;

   localparam logic [REG_W-1:0] COUNT_MAX   = 14'h3FFF;
   localparam logic [REG_W-1:0] TOTAL_RESET = 14'd8192;

   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_BLK = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_VOL_BLKS  = 1'b1;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_TEST  = 1'b1;

   localparam logic [ACT_W-1:0] ACT_NONE  = 4'd0;
   localparam logic [ACT_W-1:0] ACT_TAKE  = 4'd1;
   localparam logic [ACT_W-1:0] ACT_DIVQ  = 4'd2;
   localparam logic [ACT_W-1:0] ACT_DIVR  = 4'd3;
   localparam logic [ACT_W-1:0] ACT_RDQ   = 4'd4;
   localparam logic [ACT_W-1:0] ACT_SCAN  = 4'd5;
   localparam logic [ACT_W-1:0] ACT_WRITE = 4'd6;
   localparam logic [ACT_W-1:0] ACT_TEST  = 4'd7;
   localparam logic [ACT_W-1:0] ACT_OUT   = 4'd8;
   localparam logic [ACT_W-1:0] ACT_CLEAR = 4'd9;

   localparam logic [CND_W-1:0] CND_NEVER   = 4'd0;
   localparam logic [CND_W-1:0] CND_ALWAYS  = 4'd1;
   localparam logic [CND_W-1:0] CND_NOREQ   = 4'd2;
   localparam logic [CND_W-1:0] CND_TEST    = 4'd3;
   localparam logic [CND_W-1:0] CND_EMPTY   = 4'd4;
   localparam logic [CND_W-1:0] CND_MORE    = 4'd5;
   localparam logic [CND_W-1:0] CND_MISS    = 4'd6;
   localparam logic [CND_W-1:0] CND_BUSY    = 4'd7;
   localparam logic [CND_W-1:0] CND_CLRMORE = 4'd8;

   localparam logic [STEP_W-1:0] S_IDLE = 4'd0;
   localparam logic [STEP_W-1:0] S_DIV1 = 4'd1;
   localparam logic [STEP_W-1:0] S_DIV2 = 4'd2;
   localparam logic [STEP_W-1:0] S_ACHK = 4'd3;
   localparam logic [STEP_W-1:0] S_SCAN = 4'd4;
   localparam logic [STEP_W-1:0] S_AEND = 4'd5;
   localparam logic [STEP_W-1:0] S_AWR  = 4'd6;
   localparam logic [STEP_W-1:0] S_TRD  = 4'd7;
   localparam logic [STEP_W-1:0] S_TRES = 4'd8;
   localparam logic [STEP_W-1:0] S_FIN  = 4'd9;
   localparam logic [STEP_W-1:0] S_CLR  = 4'd10;

   typedef struct packed {
      logic [ACT_W-1:0]  act;
      logic [CND_W-1:0]  cond;
      logic [STEP_W-1:0] jump;
      logic [STEP_W-1:0] next;
   } ctrl_type;

   typedef struct packed {
      logic is_test;
      logic empty;
      logic more;
      logic miss;
      logic busy;
      logic clr_more;
   } status_type;

   function automatic ctrl_type ucode(input logic [STEP_W-1:0] step);
      ctrl_type w;
      unique case (step)
         S_IDLE:  w = '{ACT_TAKE,  CND_NOREQ,   S_IDLE, S_DIV1};
         S_DIV1:  w = '{ACT_DIVQ,  CND_NEVER,   S_IDLE, S_DIV2};
         S_DIV2:  w = '{ACT_DIVR,  CND_TEST,    S_TRD,  S_ACHK};
         S_ACHK:  w = '{ACT_RDQ,   CND_EMPTY,   S_FIN,  S_SCAN};
         S_SCAN:  w = '{ACT_SCAN,  CND_MORE,    S_SCAN, S_AEND};
         S_AEND:  w = '{ACT_NONE,  CND_MISS,    S_FIN,  S_AWR};
         S_AWR:   w = '{ACT_WRITE, CND_NEVER,   S_IDLE, S_FIN};
         S_TRD:   w = '{ACT_RDQ,   CND_NEVER,   S_IDLE, S_TRES};
         S_TRES:  w = '{ACT_TEST,  CND_NEVER,   S_IDLE, S_FIN};
         S_FIN:   w = '{ACT_OUT,   CND_BUSY,    S_FIN,  S_IDLE};
         S_CLR:   w = '{ACT_CLEAR, CND_CLRMORE, S_CLR,  S_IDLE};
         default: w = '{ACT_NONE,  CND_ALWAYS,  S_IDLE, S_IDLE};
      endcase
      return w;
   endfunction

endpackage

@@ rtl/bba_if.sv @@
// ----------------------------------------------------------------------------
// bba_if
// Request and response channels of the bitmap block allocator.
// ----------------------------------------------------------------------------
interface bba_req_if;
   logic        valid;
   logic        ready;
   logic        op;
   logic [12:0] block_index;

   modport source (output valid, output op, output block_index, input ready);
   modport sink   (input valid, input op, input block_index, output ready);
endinterface

interface bba_rsp_if;
   logic        valid;
   logic        ready;
   logic [12:0] block_number;
   logic        out_of_space;
   logic        is_used;
   logic [13:0] free_count;

   modport source (output valid, output block_number, output out_of_space,
                   output is_used, output free_count, input ready);
   modport sink   (input valid, input block_number, input out_of_space,
                   input is_used, input free_count, output ready);
endinterface

@@ rtl/bba_ram.sv @@
// ----------------------------------------------------------------------------
// bba_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bba_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                                      clock,
   input  logic                                      we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                          wdata,
   input  logic                                      re,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                          rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/bba_seq.sv @@
// ----------------------------------------------------------------------------
// bba_seq
// Microcode sequencer: step counter, control store and jump condition select.
// ----------------------------------------------------------------------------
module bba_seq
   import bba_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  status_type status,
   output ctrl_type   ctrl
);

   logic [STEP_W-1:0] step_ff;
   logic [STEP_W-1:0] step_in;
   logic              take;

   assign ctrl = ucode(step_ff);

   always_comb begin
      unique case (ctrl.cond)
         CND_NEVER:   take = 1'b0;
         CND_ALWAYS:  take = 1'b1;
         CND_NOREQ:   take = !req_valid;
         CND_TEST:    take = status.is_test;
         CND_EMPTY:   take = status.empty;
         CND_MORE:    take = status.more;
         CND_MISS:    take = status.miss;
         CND_BUSY:    take = status.busy;
         CND_CLRMORE: take = status.clr_more;
         default:     take = 1'b0;
      endcase
      step_in = take ? ctrl.jump : ctrl.next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= S_CLR;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

@@ rtl/bba_dpath.sv @@
// ----------------------------------------------------------------------------
// bba_dpath
// Allocator datapath: registers, word divider, bitmap word scan, bitmap RAM,
// allocation counter and response register.
// ----------------------------------------------------------------------------
module bba_dpath
   import bba_pkg::*;
#(
   parameter int MAX_BLOCKS    = 8192,
   parameter int MAP_WORD_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ctrl_type             ctrl,
   output status_type           status,
   input  logic                 accept,
   input  logic                 req_op,
   input  logic [IDX_W-1:0]     req_block_index,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [REG_W-1:0]     csr_wdata,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output logic [IDX_W-1:0]     rsp_block_number,
   output logic                 rsp_out_of_space,
   output logic                 rsp_is_used,
   output logic [REG_W-1:0]     rsp_free_count
);

   localparam int MAP_WORDS = (MAX_BLOCKS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
   localparam int AW        = MAP_WORDS > 1 ? $clog2(MAP_WORDS) : 1;
   localparam int OW        = $clog2(MAP_WORD_BITS);
   localparam longint RECIP = ((64'd1 << DIV_SHIFT) + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
   localparam int RECIP_W   = $clog2(RECIP + 1);
   localparam int PROD_W    = REG_W + RECIP_W;
   localparam int QW_W      = REG_W + OW + 1;
   localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);
   localparam logic [LIM_W-1:0] MAP_CAP =
      LIM_W'(MAX_BLOCKS > (1 << REG_W) ? (1 << REG_W) : MAX_BLOCKS);
   localparam logic [LIM_W-1:0] WORD_STEP = LIM_W'(MAP_WORD_BITS);
   localparam logic [AW-1:0]    LAST_WORD = AW'(MAP_WORDS - 1);

   // config and control state
   logic [REG_W-1:0] ds_ff, ds_in;
   logic [REG_W-1:0] tot_ff, tot_in;
   logic [REG_W-1:0] cnt_ff, cnt_in;
   logic [AW-1:0]    clr_ff, clr_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // item payload
   logic                     op_ff, op_in;
   logic [IDX_W-1:0]         idx_ff, idx_in;
   logic [REG_W-1:0]         q_ff, q_in;
   logic [LIM_W-1:0]         base_ff, base_in;
   logic [OW-1:0]            off_ff, off_in;
   logic [LIM_W-1:0]         range_ff, range_in;
   logic                     found_ff, found_in;
   logic                     used_ff, used_in;
   logic [IDX_W-1:0]         num_ff, num_in;
   logic [MAP_WORD_BITS-1:0] word_ff, word_in;

   logic [IDX_W-1:0] rsp_num_ff, rsp_num_in;
   logic             rsp_oos_ff, rsp_oos_in;
   logic             rsp_used_ff, rsp_used_in;
   logic [REG_W-1:0] rsp_free_ff, rsp_free_in;

   logic [LIM_W-1:0]         lim;
   logic [LIM_W-1:0]         ds_ext;
   logic [REG_W-1:0]         div_x;
   logic [PROD_W-1:0]        prod;
   logic [QW_W-1:0]          qw_full;
   logic [MAP_WORD_BITS-1:0] rdata;
   logic [MAP_WORD_BITS-1:0] cand;
   logic [MAP_WORD_BITS-1:0] lowest;
   logic [LIM_W-1:0]         blk;
   logic [OW-1:0]            enc;
   logic                     hit;
   logic                     more_scan;
   logic                     busy;
   logic                     do_out;
   logic                     ram_we;
   logic [AW-1:0]            ram_waddr;
   logic [MAP_WORD_BITS-1:0] ram_wdata;
   logic                     ram_re;
   logic [AW-1:0]            ram_raddr;

   assign ds_ext = {1'b0, ds_ff};
   assign lim    = ({1'b0, tot_ff} < MAP_CAP) ? {1'b0, tot_ff} : MAP_CAP;
   assign div_x  = (op_ff == OP_TEST) ? {1'b0, idx_ff} : ds_ff;
   assign prod   = PROD_W'(div_x) * PROD_W'(RECIP_C);
   assign qw_full = QW_W'(q_ff) * QW_W'(MAP_WORD_BITS);

   // first clear bit of the word inside [data start, limit)
   always_comb begin
      blk = '0;
      for (int j = 0; j < MAP_WORD_BITS; j++) begin
         blk     = base_ff + LIM_W'(j);
         cand[j] = !rdata[j] && (blk >= ds_ext) && (blk < lim);
      end
      lowest = cand & (~cand + 1'b1);
      enc = '0;
      for (int j = 0; j < MAP_WORD_BITS; j++) begin
         if (lowest[j]) begin
            enc = enc | OW'(j);
         end
      end
   end

   assign hit       = |cand;
   assign more_scan = !hit && ((base_ff + WORD_STEP) < lim);
   assign busy      = rsp_valid_ff && !rsp_ready;
   assign do_out    = (ctrl.act == ACT_OUT) && !busy;

   assign status.is_test  = (op_ff == OP_TEST);
   assign status.empty    = ds_ext >= lim;
   assign status.more     = more_scan;
   assign status.miss     = !found_ff;
   assign status.busy     = busy;
   assign status.clr_more = clr_ff != LAST_WORD;

   assign ram_we    = (ctrl.act == ACT_WRITE) || (ctrl.act == ACT_CLEAR);
   assign ram_waddr = (ctrl.act == ACT_CLEAR) ? clr_ff : AW'(q_ff);
   assign ram_wdata = (ctrl.act == ACT_CLEAR) ? '0 :
                      (word_ff | (MAP_WORD_BITS'(1) << off_ff));
   assign ram_re    = (ctrl.act == ACT_RDQ) || ((ctrl.act == ACT_SCAN) && more_scan);
   assign ram_raddr = (ctrl.act == ACT_SCAN) ? AW'(q_ff + REG_W'(1)) : AW'(q_ff);

   bba_ram #(
      .WIDTH (MAP_WORD_BITS),
      .DEPTH (MAP_WORDS)
   ) u_map (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (rdata)
   );

   always_comb begin
      ds_in        = ds_ff;
      tot_in       = tot_ff;
      cnt_in       = cnt_ff;
      clr_in       = clr_ff;
      op_in        = op_ff;
      idx_in       = idx_ff;
      q_in         = q_ff;
      base_in      = base_ff;
      off_in       = off_ff;
      range_in     = range_ff;
      found_in     = found_ff;
      used_in      = used_ff;
      num_in       = num_ff;
      word_in      = word_ff;
      rsp_num_in   = rsp_num_ff;
      rsp_oos_in   = rsp_oos_ff;
      rsp_used_in  = rsp_used_ff;
      rsp_free_in  = rsp_free_ff;
      rsp_valid_in = rsp_ready ? 1'b0 : rsp_valid_ff;

      if (csr_we) begin
         case (csr_index)
            CSR_FIRST_BLK: ds_in  = csr_wdata;
            CSR_VOL_BLKS:  tot_in = csr_wdata;
            default: ;
         endcase
      end

      unique case (ctrl.act)
         ACT_TAKE: begin
            if (accept) begin
               op_in    = req_op;
               idx_in   = req_block_index;
               found_in = 1'b0;
               used_in  = 1'b0;
               num_in   = '0;
            end
         end
         ACT_DIVQ: begin
            q_in     = REG_W'(prod >> DIV_SHIFT);
            range_in = (lim > ds_ext) ? (lim - ds_ext) : '0;
         end
         ACT_DIVR: begin
            base_in = LIM_W'(qw_full);
            off_in  = OW'(div_x - REG_W'(qw_full));
         end
         ACT_SCAN: begin
            found_in = hit;
            off_in   = enc;
            word_in  = rdata;
            if (more_scan) begin
               q_in    = q_ff + REG_W'(1);
               base_in = base_ff + WORD_STEP;
            end
         end
         ACT_WRITE: begin
            if (cnt_ff != COUNT_MAX) begin
               cnt_in = cnt_ff + REG_W'(1);
            end
            num_in = IDX_W'(base_ff + LIM_W'(off_ff));
         end
         ACT_TEST: begin
            used_in = (LIM_W'(idx_ff) < ds_ext) ||
                      ((LIM_W'(idx_ff) < MAP_CAP) && rdata[off_ff]);
         end
         ACT_OUT: begin
            if (do_out) begin
               rsp_valid_in = 1'b1;
               rsp_num_in   = num_ff;
               rsp_oos_in   = (op_ff == OP_ALLOC) && !found_ff;
               rsp_used_in  = used_ff;
               rsp_free_in  = (range_ff > LIM_W'(cnt_ff)) ?
                              REG_W'(range_ff - LIM_W'(cnt_ff)) : '0;
            end
         end
         ACT_CLEAR: begin
            clr_in = clr_ff + AW'(1);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ds_ff        <= '0;
         tot_ff       <= TOTAL_RESET;
         cnt_ff       <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ds_ff        <= ds_in;
         tot_ff       <= tot_in;
         cnt_ff       <= cnt_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      idx_ff      <= idx_in;
      q_ff        <= q_in;
      base_ff     <= base_in;
      off_ff      <= off_in;
      range_ff    <= range_in;
      found_ff    <= found_in;
      used_ff     <= used_in;
      num_ff      <= num_in;
      word_ff     <= word_in;
      rsp_num_ff  <= rsp_num_in;
      rsp_oos_ff  <= rsp_oos_in;
      rsp_used_ff <= rsp_used_in;
      rsp_free_ff <= rsp_free_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_block_number = rsp_num_ff;
   assign rsp_out_of_space = rsp_oos_ff;
   assign rsp_is_used      = rsp_used_ff;
   assign rsp_free_count   = rsp_free_ff;

endmodule

@@ rtl/bitmap_block_allocator_core.sv @@
// ----------------------------------------------------------------------------
// bitmap_block_allocator_core
// First-fit block allocator over a used-block bitmap.
//
// req_chan carries one item: op (allocate or test) and block_index. rsp_chan
// returns one item per request: block_number, out_of_space, is_used and
// free_count. csr_we/csr_index/csr_wdata write the first allocatable block
// (0) and the volume size (1); write them only while no request is in flight.
// Requests are taken one at a time by a microcoded sequencer. A test steps
// through the word divider, one bitmap read and the bit test to the output
// step. An allocate steps through the word divider and the empty-range
// check, then reads bitmap words one per cycle through the single RAM read
// port, starting at the word holding the first allocatable block, and if it
// finds a free block writes that word back with the block marked used; an
// allocate on an empty range goes straight to the output step.
// After reset all ceil(MAX_BLOCKS / MAP_WORD_BITS) bitmap words (256 at the
// defaults) are cleared one word per cycle; req_chan is not ready during
// that pass. The response sits in an output register; a new request is
// accepted while it waits, and the sequencer holds in its last step until
// the receiver has taken the previous response.
// ----------------------------------------------------------------------------
module bitmap_block_allocator_core
   import bba_pkg::*;
#(
   parameter int MAX_BLOCKS    = 8192,
   parameter int MAP_WORD_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   bba_req_if.sink              req_chan,
   bba_rsp_if.source            rsp_chan,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [REG_W-1:0]     csr_wdata
);

   ctrl_type   ctrl;
   status_type status;
   logic       accept;

   assign req_chan.ready = (ctrl.act == ACT_TAKE);
   assign accept         = req_chan.valid && req_chan.ready;

   bba_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .status    (status),
      .ctrl      (ctrl)
   );

   bba_dpath #(
      .MAX_BLOCKS    (MAX_BLOCKS),
      .MAP_WORD_BITS (MAP_WORD_BITS)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .ctrl             (ctrl),
      .status           (status),
      .accept           (accept),
      .req_op           (req_chan.op),
      .req_block_index  (req_chan.block_index),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_ready        (rsp_chan.ready),
      .rsp_valid        (rsp_chan.valid),
      .rsp_block_number (rsp_chan.block_number),
      .rsp_out_of_space (rsp_chan.out_of_space),
      .rsp_is_used      (rsp_chan.is_used),
      .rsp_free_count   (rsp_chan.free_count)
   );

   // an accepted item occupies the sequencer for several steps
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_chan.ready)
      else $error("request accepted while previous item still in progress");

   a_oos_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.out_of_space) |->
         (rsp_chan.block_number == '0) && !rsp_chan.is_used)
      else $error("out-of-space response carries block number or used flag");

   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      (ctrl.act == ACT_CLEAR) |-> !rsp_chan.valid && !req_chan.ready)
      else $error("channel activity during bitmap clear");

endmodule

@@ sim/bitmap_block_allocator_core_checker.sv @@
// ----------------------------------------------------------------------------
// bitmap_block_allocator_core_checker
// Watches the request, response and register ports of the block allocator.
// It keeps its own used-block map, allocation count and window registers,
// predicts the response of every accepted request and compares each
// accepted response field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module bitmap_block_allocator_core_checker
   import bba_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   bba_req_if                   req_mon,
   bba_rsp_if                   rsp_mon,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [REG_W-1:0]     csr_wdata,
   output int                   mismatch_count,
   output int                   open_count
);

   localparam int MAP_BLOCKS = 8192;

   typedef struct packed {
      logic [IDX_W-1:0] block_number;
      logic             out_of_space;
      logic             is_used;
      logic [REG_W-1:0] free_count;
   } alloc_result_type;

   logic             used_map [MAP_BLOCKS];
   logic [REG_W-1:0] alloc_total;
   logic [REG_W-1:0] first_blk;
   logic [REG_W-1:0] vol_blks;
   alloc_result_type pending_results [$];

   function automatic logic [REG_W-1:0] blocks_free();
      int lim;
      int span;
      lim  = (int'(vol_blks) < MAP_BLOCKS) ? int'(vol_blks) : MAP_BLOCKS;
      span = (lim > int'(first_blk)) ? lim - int'(first_blk) : 0;
      return (span > int'(alloc_total)) ? REG_W'(span - int'(alloc_total)) : '0;
   endfunction

   function automatic alloc_result_type predict_request(input logic op,
                                                        input logic [IDX_W-1:0] idx);
      alloc_result_type r;
      int               lim;
      int               b;
      r = '0;
      if (op == OP_ALLOC) begin
         lim = (int'(vol_blks) < MAP_BLOCKS) ? int'(vol_blks) : MAP_BLOCKS;
         b   = int'(first_blk);
         while (b < lim && used_map[b]) b++;
         if (b < lim) begin
            used_map[b] = 1'b1;
            if (alloc_total != COUNT_MAX) alloc_total = alloc_total + 1'b1;
            r.block_number = IDX_W'(b);
         end else begin
            r.out_of_space = 1'b1;
         end
      end else begin
         r.is_used = (REG_W'(idx) < first_blk) || used_map[idx];
      end
      r.free_count = blocks_free();
      return r;
   endfunction

   task automatic note_failure(input string what, input alloc_result_type want,
                               input alloc_result_type seen);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display({"%0t mismatch, %s: expected num=%0d oos=%0b used=%0b free=%0d,",
                   " got num=%0d oos=%0b used=%0b free=%0d"},
                  $time, what, want.block_number, want.out_of_space, want.is_used,
                  want.free_count, seen.block_number, seen.out_of_space, seen.is_used,
                  seen.free_count);
   endtask

   always @(posedge clock) begin : track
      alloc_result_type seen;
      alloc_result_type want;
      if (reset) begin
         foreach (used_map[i]) used_map[i] = 1'b0;
         alloc_total = '0;
         first_blk   = '0;
         vol_blks    = TOTAL_RESET;
         pending_results.delete();
         mismatch_count = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            seen = '{rsp_mon.block_number, rsp_mon.out_of_space, rsp_mon.is_used,
                     rsp_mon.free_count};
            if (pending_results.size() == 0) begin
               note_failure("response with no request", '0, seen);
            end else begin
               want = pending_results.pop_front();
               if (seen.block_number !== want.block_number ||
                   seen.out_of_space !== want.out_of_space ||
                   seen.is_used      !== want.is_used      ||
                   seen.free_count   !== want.free_count)
                  note_failure("response", want, seen);
            end
         end
         if (csr_we) begin
            if (csr_index == CSR_FIRST_BLK) first_blk = csr_wdata;
            else if (csr_index == CSR_VOL_BLKS) vol_blks = csr_wdata;
         end
         if (req_mon.valid && req_mon.ready)
            pending_results.push_back(predict_request(req_mon.op, req_mon.block_index));
      end
      open_count <= pending_results.size();
   end

endmodule

@@ sim/bitmap_block_allocator_core_tb.sv @@
// ----------------------------------------------------------------------------
// bitmap_block_allocator_core_tb
// Drives allocate and test requests into the block allocator through a
// directed opening and a long random run over many allocation windows, with
// random gaps on both channels and long response hold-offs. The checker
// beside the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module bitmap_block_allocator_core_tb
   import bba_pkg::*;
();

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [REG_W-1:0]     csr_wdata;

   int sent_count     = 0;
   int rsp_count      = 0;
   int req_gap_lim    = 0;
   int rsp_gap_lim    = 0;
   int mismatch_count;
   int open_count;

   bba_req_if req_chan ();
   bba_rsp_if rsp_chan ();

   bitmap_block_allocator_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   bitmap_block_allocator_core_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_chan),
      .rsp_mon        (rsp_chan),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .open_count     (open_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #40_000_000;
      $display("FAIL bitmap_block_allocator_core");
      $finish;
   end

   function automatic int draw_gap(input int lim);
      return (lim == 0) ? 0 : $urandom_range(0, lim);
   endfunction

   function automatic int draw_gap_limit();
      return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 18);
   endfunction

   task automatic send_item(input logic op, input logic [IDX_W-1:0] idx);
      int gap;
      gap = draw_gap(req_gap_lim);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.op          <= op;
      req_chan.block_index <= idx;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      sent_count++;
   endtask

   // wait until every item sent has its response back
   task automatic drain(input int pause);
      int waited;
      waited = 0;
      req_chan.valid <= 1'b0;
      while (rsp_count != sent_count && waited < 50000) begin
         @(posedge clock);
         waited++;
      end
      repeat (pause) @(posedge clock);
   endtask

   task automatic set_window(input int first, input int count);
      csr_we    <= 1'b1;
      csr_index <= CSR_FIRST_BLK;
      csr_wdata <= REG_W'(first);
      @(posedge clock);
      csr_index <= CSR_VOL_BLKS;
      csr_wdata <= REG_W'(count);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // response side: random stalls, two long hold-offs to back up the block
   initial begin : receiver
      int gap;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (rsp_count % 40 == 0) rsp_gap_lim = draw_gap_limit();
         gap = (rsp_count == 30 || rsp_count == 400) ? 300 : draw_gap(rsp_gap_lim);
         if (gap > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_chan.valid) @(posedge clock);
         rsp_count++;
      end
   end

   initial begin : stimulus
      int               first;
      int               count;
      int               lo;
      int               hi;
      int               n;
      logic             op;
      logic [IDX_W-1:0] idx;

      reset                <= 1'b1;
      csr_we               <= 1'b0;
      csr_index            <= CSR_FIRST_BLK;
      csr_wdata            <= '0;
      req_chan.valid       <= 1'b0;
      req_chan.op          <= OP_ALLOC;
      req_chan.block_index <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset window
      send_item(OP_ALLOC, '0);
      send_item(OP_ALLOC, 13'h1FFF);
      send_item(OP_ALLOC, '0);
      send_item(OP_TEST, 13'd0);
      send_item(OP_TEST, 13'd2);
      send_item(OP_TEST, 13'd3);
      send_item(OP_TEST, 13'h1FFF);
      send_item(OP_TEST, 13'h1555);

      // top two blocks only: fill, then out of space
      drain(4);
      set_window(8190, 8192);
      send_item(OP_ALLOC, '0);
      send_item(OP_ALLOC, '0);
      send_item(OP_ALLOC, '0);
      send_item(OP_TEST, 13'd8189);
      send_item(OP_TEST, 13'h1FFF);
      send_item(OP_TEST, 13'd0);

      // data start past the bitmap: empty range, everything below reads used
      drain(4);
      set_window(16383, 16383);
      send_item(OP_ALLOC, '0);
      send_item(OP_TEST, 13'h1FFF);

      // zero volume: tests beyond the volume report the stored bit
      drain(4);
      set_window(0, 0);
      send_item(OP_ALLOC, '0);
      send_item(OP_TEST, 13'd5000);
      send_item(OP_TEST, 13'd1);

      // range smaller than the allocation count
      drain(4);
      set_window(100, 101);
      send_item(OP_ALLOC, '0);
      send_item(OP_ALLOC, '0);

      while (sent_count < 900) begin
         drain(4);
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               first = $urandom_range(0, 8191);
               count = first + $urandom_range(1, 48);
            end
            4, 5: begin
               first = $urandom_range(0, 1024);
               count = $urandom_range(first + 1, 8192);
            end
            6: begin
               first = 0;
               count = 8192;
            end
            7: begin
               first = $urandom_range(0, 16383);
               count = $urandom_range(0, 16383);
            end
            default: begin
               first = 8192 - $urandom_range(1, 64);
               count = $urandom_range(0, 1) ? 8192 : 16383;
            end
         endcase
         set_window(first, count);
         req_gap_lim = draw_gap_limit();
         lo = (first > 4) ? first - 4 : 0;
         hi = (count + 4 < 8191) ? count + 4 : 8191;
         n  = $urandom_range(15, 50);
         repeat (n) begin
            op = ($urandom_range(0, 99) < 65) ? OP_ALLOC : OP_TEST;
            if ($urandom_range(0, 1) && lo <= hi) idx = IDX_W'($urandom_range(lo, hi));
            else idx = IDX_W'($urandom);
            send_item(op, idx);
         end
      end

      drain(40);
      if (mismatch_count == 0 && open_count == 0 && rsp_count == sent_count)
         $display("PASS bitmap_block_allocator_core");
      else
         $display("FAIL bitmap_block_allocator_core");
      $finish;
   end

endmodule
